>>> hdl/stereo_ff_fb_delay_effect_top_assert.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared check macros for the stereo delay effect, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef STEREO_FF_FB_DELAY_EFFECT_TOP_ASSERT_SVH
`define STEREO_FF_FB_DELAY_EFFECT_TOP_ASSERT_SVH

// same-cycle implication
`define SFFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sffd check failed");

// next-cycle implication
`define SFFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sffd check failed");

`endif

>>> hdl/sffd_pkg.sv
// ----------------------------------------------------------------------------
// sffd_pkg
// shared constants and types of the stereo feedforward/feedback delay effect
// ----------------------------------------------------------------------------
`default_nettype none

package sffd_pkg;

  localparam int DEPTH_DEFAULT              = 4096;
  localparam int SAMPLE_BITS_DEFAULT        = 24;
  localparam int GAIN_FRACTION_BITS_DEFAULT = 12;

  localparam int GAIN_BITS      = 16;
  localparam int DELAY_BITS     = 12;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [GAIN_BITS-1:0] DRY_GAIN_RESET = GAIN_BITS'(4096);
  localparam logic [GAIN_BITS-1:0] FF_GAIN_RESET  = GAIN_BITS'(0);
  localparam logic [GAIN_BITS-1:0] FB_GAIN_RESET  = GAIN_BITS'(0);
  localparam logic [GAIN_BITS-1:0] OUT_GAIN_RESET = GAIN_BITS'(4096);

  typedef enum logic [2:0] {
    REG_DRY_GAIN = 3'd0,
    REG_FF_GAIN  = 3'd1,
    REG_FB_GAIN  = 3'd2,
    REG_OUT_GAIN = 3'd3,
    REG_FF_DELAY = 3'd4,
    REG_FB_DELAY = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]  dry_gain;
    logic [GAIN_BITS-1:0]  ff_gain;
    logic [GAIN_BITS-1:0]  fb_gain;
    logic [GAIN_BITS-1:0]  out_gain;
    logic [DELAY_BITS-1:0] ff_delay;
    logic [DELAY_BITS-1:0] fb_delay;
  } cfg_t;

  typedef struct packed {
    logic ff_zero;
    logic ff_valid;
    logic fb_zero;
    logic fb_valid;
  } tap_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/sffd_regs.sv
// ----------------------------------------------------------------------------
// sffd_regs
// apb register file for gains and tap delays
// ----------------------------------------------------------------------------
`default_nettype none

module sffd_regs #(
  parameter int DEPTH = sffd_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sffd_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [sffd_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [sffd_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output sffd_pkg::cfg_t                      cfg
);

  localparam int DB = sffd_pkg::DELAY_BITS;
  localparam int GB = sffd_pkg::GAIN_BITS;
  localparam int AB = sffd_pkg::APB_ADDR_BITS;
  localparam int XB = sffd_pkg::APB_DATA_BITS;

  sffd_pkg::reg_idx_t idx;
  logic               wr;
  logic               delay_ok;

  assign pready   = 1'b1;
  assign idx      = sffd_pkg::reg_idx_t'(paddr[AB-1:2]);
  assign wr       = psel & penable & pwrite & pready;
  assign delay_ok = 32'(pwdata[DB-1:0]) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dry_gain <= sffd_pkg::DRY_GAIN_RESET;
      cfg.ff_gain  <= sffd_pkg::FF_GAIN_RESET;
      cfg.fb_gain  <= sffd_pkg::FB_GAIN_RESET;
      cfg.out_gain <= sffd_pkg::OUT_GAIN_RESET;
      cfg.ff_delay <= '0;
      cfg.fb_delay <= '0;
    end else if (wr) begin
      case (idx)
        sffd_pkg::REG_DRY_GAIN: cfg.dry_gain <= pwdata[GB-1:0];
        sffd_pkg::REG_FF_GAIN:  cfg.ff_gain  <= pwdata[GB-1:0];
        sffd_pkg::REG_FB_GAIN:  cfg.fb_gain  <= pwdata[GB-1:0];
        sffd_pkg::REG_OUT_GAIN: cfg.out_gain <= pwdata[GB-1:0];
        sffd_pkg::REG_FF_DELAY: begin
          if (delay_ok) cfg.ff_delay <= pwdata[DB-1:0];
        end
        sffd_pkg::REG_FB_DELAY: begin
          if (delay_ok) cfg.fb_delay <= pwdata[DB-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sffd_pkg::REG_DRY_GAIN: prdata = XB'($signed(cfg.dry_gain));
      sffd_pkg::REG_FF_GAIN:  prdata = XB'($signed(cfg.ff_gain));
      sffd_pkg::REG_FB_GAIN:  prdata = XB'($signed(cfg.fb_gain));
      sffd_pkg::REG_OUT_GAIN: prdata = XB'($signed(cfg.out_gain));
      sffd_pkg::REG_FF_DELAY: prdata = XB'(cfg.ff_delay);
      sffd_pkg::REG_FB_DELAY: prdata = XB'(cfg.fb_delay);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/sffd_front.sv
// ----------------------------------------------------------------------------
// sffd_front
// takes input frames, tracks the frame position and classifies both taps
// ----------------------------------------------------------------------------
`default_nettype none

module sffd_front #(
  parameter int DEPTH       = sffd_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = sffd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sffd_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_BITS-1:0]     in_left,
  input  logic [SAMPLE_BITS-1:0]     in_right,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [$clog2(DEPTH)-1:0]   e_pos,
  output logic [$clog2(DEPTH)-1:0]   e_ffi,
  output logic [$clog2(DEPTH)-1:0]   e_fbi,
  output sffd_pkg::tap_ctrl_t        e_ctrl,
  output logic [SAMPLE_BITS-1:0]     e_left,
  output logic [SAMPLE_BITS-1:0]     e_right
);

  localparam int PW = $clog2(DEPTH);

  logic [PW-1:0] pos;
  logic          filled;
  logic [31:0]   pos32;
  logic [31:0]   ffd32;
  logic [31:0]   fbd32;
  logic [31:0]   ff_idx;
  logic [31:0]   fb_idx;
  logic          ff_ge;
  logic          fb_ge;
  logic          last;

  assign in_ready = !q_full;
  assign q_push   = in_valid & in_ready;
  assign e_left   = in_left;
  assign e_right  = in_right;
  assign e_pos    = pos;

  always_comb begin
    pos32  = 32'(pos);
    ffd32  = 32'(cfg.ff_delay);
    fbd32  = 32'(cfg.fb_delay);
    ff_ge  = pos32 >= ffd32;
    fb_ge  = pos32 >= fbd32;
    ff_idx = ff_ge ? pos32 - ffd32 : pos32 + 32'(DEPTH) - ffd32;
    fb_idx = fb_ge ? pos32 - fbd32 : pos32 + 32'(DEPTH) - fbd32;
    e_ffi  = ff_idx[PW-1:0];
    e_fbi  = fb_idx[PW-1:0];
    // a tap index that wraps below slot zero is valid only once the history has wrapped
    e_ctrl.ff_zero  = cfg.ff_delay == '0;
    e_ctrl.ff_valid = filled | ff_ge;
    e_ctrl.fb_zero  = cfg.fb_delay == '0;
    e_ctrl.fb_valid = filled | fb_ge;
    last = pos32 == 32'(DEPTH - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
    end else if (q_push) begin
      if (last) begin
        pos    <= '0;
        filled <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sffd_queue.sv
// ----------------------------------------------------------------------------
// sffd_queue
// short fifo between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_ff_fb_delay_effect_top_assert.svh"

module sffd_queue #(
  parameter int WIDTH   = 8,
  parameter int ENTRIES = sffd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [WIDTH-1:0] slots [ENTRIES];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = count == CW'(ENTRIES);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(ENTRIES - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == AW'(ENTRIES - 1)) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SFFD_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count == $past(count) + 1'b1)
  `SFFD_ASSERT_NOW(a_read_nonempty, rd_en, !empty)
  `SFFD_ASSERT_NOW(a_write_not_full, wr_en, !full)

endmodule

`default_nettype wire

>>> hdl/sffd_back.sv
// ----------------------------------------------------------------------------
// sffd_back
// history memories, tap arithmetic per channel and the output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_ff_fb_delay_effect_top_assert.svh"

module sffd_back #(
  parameter int DEPTH              = sffd_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS        = sffd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_FRACTION_BITS = sffd_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sffd_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [$clog2(DEPTH)-1:0]   e_pos,
  input  logic [$clog2(DEPTH)-1:0]   e_ffi,
  input  logic [$clog2(DEPTH)-1:0]   e_fbi,
  input  sffd_pkg::tap_ctrl_t        e_ctrl,
  input  logic [SAMPLE_BITS-1:0]     e_left,
  input  logic [SAMPLE_BITS-1:0]     e_right,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [SAMPLE_BITS-1:0]     out_left,
  output logic [SAMPLE_BITS-1:0]     out_right
);

  localparam int S    = SAMPLE_BITS;
  localparam int G    = sffd_pkg::GAIN_BITS;
  localparam int F    = GAIN_FRACTION_BITS;
  localparam int PW   = $clog2(DEPTH);
  localparam int PR_W = S + G;
  localparam int P_W  = PR_W + 1;
  localparam int T_W  = P_W - F;
  localparam int FB_W = T_W + G;
  localparam int S_W  = FB_W + 1;
  localparam int M_W  = S_W - F;
  localparam int O_W  = M_W + G;
  localparam int Y_W  = O_W - F;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PROD  = 6'b000010,
    ST_FBK   = 6'b000100,
    ST_MIX   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_wr;

  logic [2*S-1:0] in_hist  [DEPTH];
  logic [2*S-1:0] out_hist [DEPTH];
  logic [2*S-1:0] in_rd;
  logic [2*S-1:0] out_rd;

  sffd_pkg::tap_ctrl_t ctrl_q;
  logic [PW-1:0]       pos_q;

  logic signed [S-1:0]    x_q     [2];
  logic signed [S-1:0]    xd      [2];
  logic signed [PR_W-1:0] pr_dry  [2];
  logic signed [PR_W-1:0] pr_ff   [2];
  logic signed [P_W-1:0]  p_next  [2];
  logic signed [P_W-1:0]  p_q     [2];
  logic signed [T_W-1:0]  tap     [2];
  logic signed [FB_W-1:0] fbp_next[2];
  logic signed [FB_W-1:0] fbp_q   [2];
  logic signed [S_W-1:0]  sum     [2];
  logic signed [M_W-1:0]  m_next  [2];
  logic signed [M_W-1:0]  m_q     [2];
  logic signed [O_W-1:0]  o_next  [2];
  logic signed [O_W-1:0]  o_q     [2];
  logic signed [Y_W-1:0]  y_full  [2];
  logic [S-1:0]           y_sat   [2];

  // control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_wr     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_PROD;
        end
      end
      ST_PROD:  state_next = ST_FBK;
      ST_FBK:   state_next = ST_MIX;
      ST_MIX:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_valid || m_ready) begin
          out_wr     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_wr) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  // history memories
  always_ff @(posedge clk) begin
    if (q_pop) begin
      in_hist[e_pos] <= {e_right, e_left};
      in_rd          <= in_hist[e_ffi];
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) out_hist[pos_q] <= {y_sat[1], y_sat[0]};
    if (q_pop) out_rd <= out_hist[e_fbi];
  end

  // datapath, one lane per channel
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      if (ctrl_q.ff_zero) xd[ch] = x_q[ch];
      else if (ctrl_q.ff_valid) xd[ch] = in_rd[ch*S +: S];
      else xd[ch] = '0;
      pr_dry[ch] = $signed(cfg.dry_gain) * x_q[ch];
      pr_ff[ch]  = $signed(cfg.ff_gain) * xd[ch];
      p_next[ch] = P_W'(pr_dry[ch]) + P_W'(pr_ff[ch]);

      if (ctrl_q.fb_zero) tap[ch] = T_W'(p_q[ch] >>> F);
      else if (ctrl_q.fb_valid) tap[ch] = T_W'($signed(out_rd[ch*S +: S]));
      else tap[ch] = '0;
      fbp_next[ch] = $signed(cfg.fb_gain) * tap[ch];

      sum[ch]    = S_W'(p_q[ch]) + S_W'(fbp_q[ch]);
      m_next[ch] = M_W'(sum[ch] >>> F);

      o_next[ch] = $signed(cfg.out_gain) * m_q[ch];

      y_full[ch] = Y_W'(o_q[ch] >>> F);
      if ((&y_full[ch][Y_W-1:S-1]) || !(|y_full[ch][Y_W-1:S-1])) begin
        y_sat[ch] = y_full[ch][S-1:0];
      end else if (y_full[ch][Y_W-1]) begin
        y_sat[ch] = {1'b1, {(S-1){1'b0}}};
      end else begin
        y_sat[ch] = {1'b0, {(S-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctrl_q <= e_ctrl;
      pos_q  <= e_pos;
      x_q[0] <= e_left;
      x_q[1] <= e_right;
    end
    for (int ch = 0; ch < 2; ch++) begin
      if (state == ST_PROD)  p_q[ch]   <= p_next[ch];
      if (state == ST_FBK)   fbp_q[ch] <= fbp_next[ch];
      if (state == ST_MIX)   m_q[ch]   <= m_next[ch];
      if (state == ST_SCALE) o_q[ch]   <= o_next[ch];
    end
    if (out_wr) begin
      out_left  <= y_sat[0];
      out_right <= y_sat[1];
    end
  end

  `SFFD_ASSERT_NEXT(a_done_to_idle, out_wr, (state == ST_IDLE) && m_valid)
  `SFFD_ASSERT_NOW(a_valid_from_done, $rose(m_valid), $past(state == ST_DONE))
  `SFFD_ASSERT_NOW(a_zero_tap_valid, q_pop, !(e_ctrl.ff_zero && !e_ctrl.ff_valid))

endmodule

`default_nettype wire

>>> hdl/stereo_ff_fb_delay_effect_top.sv
// flow: an input transfer enters the queue; the idle back end pops it and finishes
//   one stereo frame before it pops the next, in the back end's step sequence
//   (memory read, two product stages, feedback mix, output gain, saturate)
// reset: registers return to their defaults, queue and output register empty;
//   history memories are not swept, a fill mark reads unwritten slots as zero
// ----------------------------------------------------------------------------
// stereo_ff_fb_delay_effect_top
// stereo comb delay with feedforward and feedback taps, apb configured
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_ff_fb_delay_effect_top #(
  parameter int DEPTH              = sffd_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS        = sffd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_FRACTION_BITS = sffd_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [sffd_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [sffd_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [sffd_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                    pready,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // sample_left, sample_right, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_left, out_right, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata
);

  localparam int S       = SAMPLE_BITS;
  localparam int PW      = $clog2(DEPTH);
  localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int QW      = $bits(sffd_pkg::tap_ctrl_t) + 3*PW + 2*S;

  sffd_pkg::cfg_t      cfg;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  logic [QW-1:0]       q_din;
  logic [QW-1:0]       q_dout;

  logic [PW-1:0]       f_pos;
  logic [PW-1:0]       f_ffi;
  logic [PW-1:0]       f_fbi;
  sffd_pkg::tap_ctrl_t f_ctrl;
  logic [S-1:0]        f_left;
  logic [S-1:0]        f_right;

  logic [PW-1:0]       b_pos;
  logic [PW-1:0]       b_ffi;
  logic [PW-1:0]       b_fbi;
  sffd_pkg::tap_ctrl_t b_ctrl;
  logic [S-1:0]        b_left;
  logic [S-1:0]        b_right;

  logic [S-1:0]        out_left;
  logic [S-1:0]        out_right;

  sffd_regs #(
    .DEPTH (DEPTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sffd_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_left  (s_tdata[S-1:0]),
    .in_right (s_tdata[2*S-1:S]),
    .q_full   (q_full),
    .q_push   (q_push),
    .e_pos    (f_pos),
    .e_ffi    (f_ffi),
    .e_fbi    (f_fbi),
    .e_ctrl   (f_ctrl),
    .e_left   (f_left),
    .e_right  (f_right)
  );

  assign q_din = {f_ctrl, f_pos, f_ffi, f_fbi, f_right, f_left};

  sffd_queue #(
    .WIDTH   (QW),
    .ENTRIES (sffd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .din   (q_din),
    .full  (q_full),
    .rd_en (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_ctrl, b_pos, b_ffi, b_fbi, b_right, b_left} = q_dout;

  sffd_back #(
    .DEPTH              (DEPTH),
    .SAMPLE_BITS        (SAMPLE_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .e_pos     (b_pos),
    .e_ffi     (b_ffi),
    .e_fbi     (b_fbi),
    .e_ctrl    (b_ctrl),
    .e_left    (b_left),
    .e_right   (b_right),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .out_left  (out_left),
    .out_right (out_right)
  );

  assign m_tdata = TDATA_W'({out_right, out_left});

endmodule

`default_nettype wire

>>> test/tb_stereo_ff_fb_delay_effect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_ff_fb_delay_effect_top
// self-checking bench for the stereo feedforward/feedback comb delay. A
// directed table covers unity and saturating gains, ignored register writes,
// zero and maximum tap delays. Random gain/delay settings and random frames
// follow under several stall patterns, draining every result before each new
// setting and once within a phase. Outputs match a bit-exact predictor or the table.
// ----------------------------------------------------------------------------

module tb_stereo_ff_fb_delay_effect_top;

  localparam int HIST_DEPTH     = sffd_pkg::DEPTH_DEFAULT;
  localparam int SAMPLE_W       = sffd_pkg::SAMPLE_BITS_DEFAULT;
  localparam int FRAC_BITS      = sffd_pkg::GAIN_FRACTION_BITS_DEFAULT;
  localparam int GAIN_BITS      = sffd_pkg::GAIN_BITS;
  localparam int DELAY_BITS     = sffd_pkg::DELAY_BITS;
  localparam int APB_ADDR_BITS  = sffd_pkg::APB_ADDR_BITS;
  localparam int APB_DATA_BITS  = sffd_pkg::APB_DATA_BITS;
  localparam int TDATA_BITS     = ((2*SAMPLE_W+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 106;
  localparam int NUM_PHASES     = 8;
  localparam int NUM_ROWS       = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // left in the low bits, as on the stream
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam logic [APB_ADDR_BITS-1:0] ADDR_DRY_GAIN = {sffd_pkg::REG_DRY_GAIN, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_FF_GAIN  = {sffd_pkg::REG_FF_GAIN, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_FB_GAIN  = {sffd_pkg::REG_FB_GAIN, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_OUT_GAIN = {sffd_pkg::REG_OUT_GAIN, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_FF_DELAY = {sffd_pkg::REG_FF_DELAY, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_FB_DELAY = {sffd_pkg::REG_FB_DELAY, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_SPARE_A  = {REG_SPARE_A, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_SPARE_B  = {REG_SPARE_B, 2'b00};

  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [APB_ADDR_BITS-1:0]  addr;
    logic [APB_DATA_BITS-1:0]  value;
    sample_t                   in_left;
    sample_t                   in_right;
    logic                      checked;
    sample_t                   out_left;
    sample_t                   out_right;
  } dir_row_t;

  localparam sample_t Z = '0;

  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_FRAME, '0, '0, Z, Z, 1'b1, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
    '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
    '{ROW_FRAME, '0, '0, -24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1},
    '{ROW_FRAME, '0, '0, 24'h555555, 24'haaaaaa, 1'b1, 24'h555555, 24'haaaaaa},
    '{ROW_WRITE, ADDR_DRY_GAIN, 32'h0000_7fff, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_OUT_GAIN, 32'h0000_7fff, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
    '{ROW_FRAME, '0, '0, 24'sd1, -24'sd1, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_DRY_GAIN, 32'h0000_8000, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_OUT_GAIN, 32'hffff_8000, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
    '{ROW_WRITE, ADDR_SPARE_A, 32'h1234_5678, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_SPARE_B, 32'hffff_ffff, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_DRY_GAIN, 32'd4096, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_OUT_GAIN, 32'd4096, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd100, -24'sd100, 1'b1, 24'sd100, -24'sd100},
    '{ROW_WRITE, ADDR_FF_GAIN, 32'd2048, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd4096, -24'sd4096, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FF_DELAY, 32'd2, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd1000, -24'sd1000, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd2000, -24'sd2000, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd3000, 24'sd3000, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FB_GAIN, 32'h0000_2000, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd512, -24'sd512, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FB_DELAY, 32'd1, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FF_DELAY, 32'habcd_f003, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd10000, -24'sd10000, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, -24'sd7, 24'sd7, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd123456, -24'sd654321, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FF_DELAY, 32'd4095, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FB_DELAY, 32'h0000_0fff, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd4000, -24'sd4000, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, 24'sd5000, -24'sd5000, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FF_GAIN, 32'h0000_8000, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FB_GAIN, 32'h0000_8000, Z, Z, 1'b0, Z, Z},
    '{ROW_WRITE, ADDR_FB_DELAY, 32'd1, Z, Z, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, Z, Z},
    '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MIN, 1'b0, Z, Z}
  };

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [APB_ADDR_BITS-1:0]  paddr    = '0;
  logic [APB_DATA_BITS-1:0]  pwdata   = '0;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [TDATA_BITS-1:0]     s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [TDATA_BITS-1:0]     m_tdata;

  stereo_ff_fb_delay_effect_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // comb delay predictor state
  frame_t                 input_frames  [HIST_DEPTH];
  frame_t                 output_frames [HIST_DEPTH];
  int                     write_pos;
  logic signed [GAIN_BITS-1:0] gain_dry, gain_ff, gain_fb, gain_out;
  logic [DELAY_BITS-1:0]  delay_ff, delay_fb;

  frame_t expected_frames [$];
  int     mismatch_count = 0;
  int     stall_cycles   = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  function automatic void apply_register(logic [2:0] idx, logic [APB_DATA_BITS-1:0] value);
    case (idx)
      sffd_pkg::REG_DRY_GAIN: gain_dry = value[GAIN_BITS-1:0];
      sffd_pkg::REG_FF_GAIN:  gain_ff  = value[GAIN_BITS-1:0];
      sffd_pkg::REG_FB_GAIN:  gain_fb  = value[GAIN_BITS-1:0];
      sffd_pkg::REG_OUT_GAIN: gain_out = value[GAIN_BITS-1:0];
      sffd_pkg::REG_FF_DELAY: begin
        if (int'(value[DELAY_BITS-1:0]) < HIST_DEPTH) delay_ff = value[DELAY_BITS-1:0];
      end
      sffd_pkg::REG_FB_DELAY: begin
        if (int'(value[DELAY_BITS-1:0]) < HIST_DEPTH) delay_fb = value[DELAY_BITS-1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic sample_t mix_channel(sample_t x, sample_t xd, sample_t yd);
    longint p, tap, s, m, y;
    p = longint'(gain_dry) * longint'(x) + longint'(gain_ff) * longint'(xd);
    // zero feedback delay feeds back the unsaturated partial sum
    tap = (delay_fb == 0) ? (p >>> FRAC_BITS) : longint'(yd);
    s = p + longint'(gain_fb) * tap;
    m = s >>> FRAC_BITS;
    y = (longint'(gain_out) * m) >>> FRAC_BITS;
    if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
    else if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
    return sample_t'(y);
  endfunction

  function automatic frame_t predict_frame(frame_t x);
    int     ffi, fbi;
    frame_t y;
    input_frames[write_pos] = x;
    ffi = (write_pos + HIST_DEPTH - int'(delay_ff)) % HIST_DEPTH;
    fbi = (write_pos + HIST_DEPTH - int'(delay_fb)) % HIST_DEPTH;
    y.left  = mix_channel(x.left, input_frames[ffi].left, output_frames[fbi].left);
    y.right = mix_channel(x.right, input_frames[ffi].right, output_frames[fbi].right);
    output_frames[write_pos] = y;
    write_pos = (write_pos + 1) % HIST_DEPTH;
    return y;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2:    return sample_t'(int'($urandom_range(0, 8192)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [APB_DATA_BITS-1:0] rand_gain_word(int centre, int spread);
    logic [GAIN_BITS-1:0] g;
    case ($urandom_range(0, 9))
      0:       g = GAIN_BITS'($urandom);
      1:       g = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: g = GAIN_BITS'(centre - spread + int'($urandom_range(0, 2*spread)));
    endcase
    return {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000, g};
  endfunction

  function automatic logic [APB_DATA_BITS-1:0] rand_delay_word();
    logic [DELAY_BITS-1:0] d;
    case ($urandom_range(0, 9))
      0, 1:    d = '0;
      2:       d = '1;
      3, 4:    d = DELAY_BITS'($urandom);
      default: d = DELAY_BITS'($urandom_range(1, 8));
    endcase
    return {($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'h00000, d};
  endfunction

  task automatic apb_write(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(addr[APB_ADDR_BITS-1:2], data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // typed expectation replaces the predicted one, predictor still advances
  task automatic send_frame(frame_t x, logic typed, frame_t typed_out);
    frame_t y;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= TDATA_BITS'(x);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    y = predict_frame(x);
    expected_frames.push_back(typed ? typed_out : y);
  endtask

  task automatic load_random_config();
    wait_results_drained();
    apb_write(ADDR_DRY_GAIN, rand_gain_word(0, 6000));
    apb_write(ADDR_FF_GAIN, rand_gain_word(0, 5000));
    apb_write(ADDR_FB_GAIN, rand_gain_word(0, 3000));
    apb_write(ADDR_OUT_GAIN, rand_gain_word(4096, 2048));
    apb_write(ADDR_FF_DELAY, rand_delay_word());
    apb_write(ADDR_FB_DELAY, rand_delay_word());
    if ($urandom_range(0, 3) == 0)
      apb_write($urandom_range(0, 1) ? ADDR_SPARE_A : ADDR_SPARE_B, $urandom);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    frame_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = frame_t'(m_tdata[2*SAMPLE_W-1:0]);
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected output transfer, got left %0d right %0d",
                 $time, got.left, got.right);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (got.left !== want.left) begin
          $display("%0t: out_left expected %0d, got %0d", $time, want.left, got.left);
          mismatch_count++;
        end
        if (got.right !== want.right) begin
          $display("%0t: out_right expected %0d, got %0d", $time, want.right, got.right);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    frame_t   x, y;
    foreach (input_frames[i]) begin
      input_frames[i]  = '0;
      output_frames[i] = '0;
    end
    write_pos = 0;
    gain_dry  = sffd_pkg::DRY_GAIN_RESET;
    gain_ff   = sffd_pkg::FF_GAIN_RESET;
    gain_fb   = sffd_pkg::FB_GAIN_RESET;
    gain_out  = sffd_pkg::OUT_GAIN_RESET;
    delay_ff  = '0;
    delay_fb  = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        wait_results_drained();
        apb_write(row.addr, row.value);
      end else begin
        x.left  = row.in_left;
        x.right = row.in_right;
        y.left  = row.out_left;
        y.right = row.out_right;
        send_frame(x, row.checked, y);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_random_config();
      set_idle_mode(ph % 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2)
          wait_results_drained();
        x.left  = rand_sample();
        x.right = rand_sample();
        send_frame(x, 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> stereo_ff_fb_delay_effect_top.f
+incdir+hdl
hdl/sffd_pkg.sv
hdl/sffd_regs.sv
hdl/sffd_front.sv
hdl/sffd_queue.sv
hdl/sffd_back.sv
hdl/stereo_ff_fb_delay_effect_top.sv
test/tb_stereo_ff_fb_delay_effect_top.sv
